// ===== rtl/segment_penalty_contact_macros.svh =====
// Assertion macros shared by the segment penalty contact RTL.
// Each macro expects i_clk and i_rst_n to exist in the module that uses it.
`ifndef SEGMENT_PENALTY_CONTACT_MACROS_SVH
`define SEGMENT_PENALTY_CONTACT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SPC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/spc_pkg.sv =====
// Shared types, constants and saturation helpers for the segment penalty contact block.
// No dependencies; every RTL module imports this package.
package spc_pkg;

    localparam int QDEPTH     = 4;
    localparam int QPW        = $clog2(QDEPTH);
    localparam int QCW        = $clog2(QDEPTH + 1);

    localparam int SQRT_STEPS = 34;
    localparam int LEN_W      = 34;
    localparam int SUM_W      = 66;

    localparam int DIV_NW     = 80;
    localparam int DIV_DW     = 33;
    localparam int DIV_QW     = 48;
    localparam int DIV_STEPS  = 48;

    // Index pairs of the stiffness terms: xx, yy, zz, xy, xz, yz.
    localparam int NPAIR = 6;
    localparam int PAIR_I [NPAIR] = '{0, 1, 2, 0, 0, 1};
    localparam int PAIR_J [NPAIR] = '{0, 1, 2, 1, 2, 2};

    localparam logic [47:0]        S48_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic signed [49:0] SAT_HI  = 50'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [49:0] SAT_LO  = 50'sh3_8000_0000_0000;

    typedef struct packed {
        logic signed [31:0] node_a_x;
        logic signed [31:0] node_a_y;
        logic signed [31:0] node_a_z;
        logic signed [31:0] node_b_x;
        logic signed [31:0] node_b_y;
        logic signed [31:0] node_b_z;
        logic [31:0]        rope_diameter;
        logic [31:0]        tensile_stiffness;
    } t_in;

    typedef struct packed {
        logic [31:0]        seg_length;
        logic               in_contact;
        logic               degenerate;
        logic signed [47:0] force_x;
        logic signed [47:0] force_y;
        logic signed [47:0] force_z;
        logic signed [47:0] stiff_xx;
        logic signed [47:0] stiff_yy;
        logic signed [47:0] stiff_zz;
        logic signed [47:0] stiff_xy;
        logic signed [47:0] stiff_xz;
        logic signed [47:0] stiff_yz;
    } t_out;

    // One classified segment handed from the front end to the back end.
    typedef struct packed {
        logic [DIV_DW-1:0]  len;
        logic [DIV_DW-1:0]  twod;
        logic [31:0]        k;
        logic [2:0][31:0]   mag;
        logic [2:0]         neg;
        logic [31:0]        seg_length;
        logic               in_contact;
        logic               degenerate;
        logic               active;
    } t_work;

    function automatic logic [47:0] sat48(input logic signed [49:0] v);
        if (v > SAT_HI) begin
            return S48_MAX;
        end else if (v < SAT_LO) begin
            return SAT_LO[47:0];
        end
        return v[47:0];
    endfunction

    // Magnitude clipped to one past the positive limit, then signed.
    function automatic logic signed [49:0] signed_mag(input logic [47:0] m, input logic neg);
        logic signed [49:0] c;
        c = (m > S48_MAX) ? (SAT_HI + 50'sd1) : $signed({2'b00, m});
        return neg ? -c : c;
    endfunction

endpackage

// ===== rtl/spc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, for the back end.
// Depends on spc_pkg; quotient must fit DIV_QW bits (high numerator part below divisor).
module spc_div (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [spc_pkg::DIV_NW-1:0]  i_num,
    input  logic [spc_pkg::DIV_DW-1:0]  i_den,
    output logic [spc_pkg::DIV_QW-1:0]  o_quo
);
    import spc_pkg::*;

    logic [DIV_DW-1:0] r_rem [DIV_STEPS-1];
    logic [DIV_DW-1:0] r_den [DIV_STEPS-1];
    logic [DIV_QW-1:0] r_low [DIV_STEPS-1];
    logic [DIV_QW-1:0] r_quo [DIV_STEPS];

    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
        logic [DIV_DW-1:0] rem_in;
        logic [DIV_DW-1:0] den_in;
        logic [DIV_QW-1:0] low_in;
        logic [DIV_QW-1:0] quo_in;
        logic [DIV_DW:0]   cur;
        logic [DIV_DW:0]   dif;
        logic              ge;
        logic [DIV_QW-1:0] n_quo;

        if (j == 0) begin : g_first
            assign rem_in = DIV_DW'(i_num[DIV_NW-1:DIV_QW]);
            assign den_in = i_den;
            assign low_in = i_num[DIV_QW-1:0];
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = r_rem[j-1];
            assign den_in = r_den[j-1];
            assign low_in = r_low[j-1];
            assign quo_in = r_quo[j-1];
        end

        assign cur = {rem_in, low_in[DIV_QW-1-j]};
        assign dif = cur - {1'b0, den_in};
        assign ge  = (cur >= {1'b0, den_in});

        always_comb begin
            n_quo = quo_in;
            n_quo[DIV_QW-1-j] = ge;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quo[j] <= n_quo;
            end
        end

        if (j < DIV_STEPS - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_den[j] <= den_in;
                    r_low[j] <= low_in;
                    r_rem[j] <= ge ? dif[DIV_DW-1:0] : cur[DIV_DW-1:0];
                end
            end
        end
    end

    assign o_quo = r_quo[DIV_STEPS-1];

endmodule

// ===== rtl/spc_front.sv =====
// Front end: node differences, squared length, pipelined square root and contact test.
// Depends on spc_pkg; hands classified segments to the queue.
module spc_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  spc_pkg::t_in   i_in_data,
    output logic           o_push,
    output spc_pkg::t_work o_work,
    input  logic           i_q_full
);
    import spc_pkg::*;

    typedef struct packed {
        logic [2:0][31:0]  mag;
        logic [2:0]        neg;
        logic [DIV_DW-1:0] twod;
        logic [31:0]       k;
    } t_side;

    localparam int LAST = SQRT_STEPS - 1;

    logic              en;
    logic [2:0][31:0]  n_pa;
    logic [2:0][31:0]  n_pb;
    logic [2:0][32:0]  n_d;
    logic [2:0][32:0]  n_nd;
    t_side             n_side0;

    logic              r_v0, r_v1, r_v2;
    t_side             r_side0, r_side1, r_side2;
    logic [2:0][63:0]  r_sq;
    logic [SUM_W-1:0]  r_sum;

    logic              r_sv    [SQRT_STEPS];
    t_side             r_sside [SQRT_STEPS];
    logic [LEN_W-1:0]  r_root  [SQRT_STEPS];
    logic [36:0]       r_rem   [SQRT_STEPS-1];
    logic [SUM_W-1:0]  r_ssum  [SQRT_STEPS-1];

    logic [LEN_W-1:0]  len;
    logic              contact;

    // The whole front end holds while a finished segment cannot enter the queue.
    assign en         = !(r_sv[LAST] && i_q_full);
    assign o_in_stall = !en;

    always_comb begin
        n_pa = {i_in_data.node_a_z, i_in_data.node_a_y, i_in_data.node_a_x};
        n_pb = {i_in_data.node_b_z, i_in_data.node_b_y, i_in_data.node_b_x};
        n_side0.twod = {i_in_data.rope_diameter, 1'b0};
        n_side0.k    = i_in_data.tensile_stiffness;
        for (int i = 0; i < 3; i++) begin
            n_d[i]  = {n_pb[i][31], n_pb[i]} - {n_pa[i][31], n_pa[i]};
            n_nd[i] = 33'd0 - n_d[i];
            n_side0.neg[i] = n_d[i][32];
            n_side0.mag[i] = n_d[i][32] ? n_nd[i][31:0] : n_d[i][31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v0 <= i_in_valid;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side0 <= n_side0;
            r_side1 <= r_side0;
            r_side2 <= r_side1;
            for (int i = 0; i < 3; i++) begin
                r_sq[i] <= 64'(r_side0.mag[i]) * 64'(r_side0.mag[i]);
            end
            r_sum <= SUM_W'(r_sq[0]) + SUM_W'(r_sq[1]) + SUM_W'(r_sq[2]);
        end
    end

    // Digit-by-digit square root, two radicand bits per stage.
    for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
        localparam int P = 2 * (SQRT_STEPS - 1 - j);
        logic [LEN_W-1:0] root_in;
        logic [36:0]      rem_in;
        logic [SUM_W-1:0] sum_in;
        logic             v_in;
        t_side            side_in;
        logic [67:0]      s68;
        logic [36:0]      cur;
        logic [36:0]      trial;
        logic             ge;

        if (j == 0) begin : g_first
            assign root_in = '0;
            assign rem_in  = '0;
            assign sum_in  = r_sum;
            assign v_in    = r_v2;
            assign side_in = r_side2;
        end else begin : g_next
            assign root_in = r_root[j-1];
            assign rem_in  = r_rem[j-1];
            assign sum_in  = r_ssum[j-1];
            assign v_in    = r_sv[j-1];
            assign side_in = r_sside[j-1];
        end

        assign s68   = {2'b00, sum_in};
        assign cur   = {rem_in[34:0], s68[P+1:P]};
        assign trial = {1'b0, root_in, 2'b01};
        assign ge    = (cur >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[j] <= 1'b0;
            end else if (en) begin
                r_sv[j] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sside[j] <= side_in;
                r_root[j]  <= {root_in[LEN_W-2:0], ge};
            end
        end

        if (j < LAST) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_ssum[j] <= sum_in;
                    r_rem[j]  <= ge ? (cur - trial) : cur;
                end
            end
        end
    end

    assign len     = r_root[LAST];
    assign contact = (len < {1'b0, r_sside[LAST].twod});

    always_comb begin
        o_work.len        = len[DIV_DW-1:0];
        o_work.twod       = r_sside[LAST].twod;
        o_work.k          = r_sside[LAST].k;
        o_work.mag        = r_sside[LAST].mag;
        o_work.neg        = r_sside[LAST].neg;
        o_work.seg_length = (len[LEN_W-1:32] != '0) ? 32'hFFFF_FFFF : len[31:0];
        o_work.in_contact = contact;
        o_work.degenerate = contact && (len == '0);
        o_work.active     = contact && (len != '0);
    end

    assign o_push = r_sv[LAST] && !i_q_full;

endmodule

// ===== rtl/spc_queue.sv =====
// Short queue between the front end and the back end of the contact block.
// Depends on spc_pkg and the shared assertion macros.
`include "segment_penalty_contact_macros.svh"

module spc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  spc_pkg::t_work i_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output spc_pkg::t_work o_data
);
    import spc_pkg::*;

    t_work          r_mem [QDEPTH];
    logic [QPW-1:0] r_wr;
    logic [QPW-1:0] r_rd;
    logic [QCW-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_full  = (r_count == QCW'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];

    `SPC_ASSERT_IMP(a_q_no_underflow, i_pop, r_count != '0, "pop from empty queue")
    `SPC_ASSERT_IMP(a_q_no_overflow, i_push, r_count != QCW'(QDEPTH), "push into full queue")
    `SPC_ASSERT_NXT(a_q_count_up, i_push && !i_pop, r_count == $past(r_count) + 1'b1, "bad count")

endmodule

// ===== rtl/spc_back.sv =====
// Back end: three chained divider banks for force and tangent stiffness, then saturation.
// Depends on spc_pkg, spc_div and the shared assertion macros.
`include "segment_penalty_contact_macros.svh"

module spc_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  spc_pkg::t_work i_q_data,
    output logic           o_q_pop,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output spc_pkg::t_out  o_out_data
);
    import spc_pkg::*;

    typedef struct packed {
        t_work             w;
        logic [DIV_QW-1:0] kl;
        logic [DIV_QW-1:0] kd;
    } t_kside;

    typedef struct packed {
        t_kside                 ks;
        logic [2:0][DIV_QW-1:0] f;
    } t_fside;

    logic                        en;
    logic                        pop;
    logic [DIV_DW-1:0]           n_gap;

    logic                        r1_v;
    t_work                       r1_w;
    logic [64:0]                 r1_me;
    logic [2:0][63:0]            r1_mt;

    logic [DIV_QW-1:0]           q_e;
    logic [DIV_QW-1:0]           q_kd;
    logic [DIV_QW-1:0]           q_kl;
    logic [2:0][DIV_QW-1:0]      q_t1;
    logic [DIV_STEPS-1:0]        r_d1_v;
    t_work                       r_d1_w [DIV_STEPS];
    t_work                       w1;

    logic                        r2_v;
    t_kside                      r2_ks;
    logic [2:0][63:0]            r2_mf;
    logic [NPAIR-1:0][47:0]      r2_hi;
    logic [NPAIR-1:0][63:0]      r2_lo;

    logic                        r3_v;
    t_kside                      r3_ks;
    logic [2:0][63:0]            r3_mf;
    logic [NPAIR-1:0][DIV_NW-1:0] r3_t2n;

    logic [2:0][DIV_QW-1:0]      q_f;
    logic [NPAIR-1:0][DIV_QW-1:0] q_t2;
    logic [DIV_STEPS-1:0]        r_d2_v;
    t_kside                      r_d2 [DIV_STEPS];
    t_kside                      ks2;
    t_fside                      n_fs;

    logic [NPAIR-1:0][DIV_QW-1:0] q_m;
    logic [DIV_STEPS-1:0]        r_d3_v;
    t_fside                      r_d3 [DIV_STEPS];
    t_fside                      fs3;

    logic signed [49:0]          n_kdiff;
    t_out                        n_out;
    logic                        r_out_valid;
    t_out                        r_out;

    // The back pipeline advances unless a finished result is held by the receiver.
    assign en      = !(r_out_valid && i_out_stall);
    assign pop     = en && i_q_valid;
    assign o_q_pop = pop;
    assign n_gap   = i_q_data.twod - i_q_data.len;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_w  <= i_q_data;
            r1_me <= 65'(i_q_data.k) * 65'(n_gap);
            for (int i = 0; i < 3; i++) begin
                r1_mt[i] <= 64'(i_q_data.k) * 64'(i_q_data.mag[i]);
            end
        end
    end

    // First bank: contact force magnitude, both spring rates, and K*|d_i|/L.
    spc_div u_div_e (
        .i_clk (i_clk), .i_en (en),
        .i_num ({15'd0, r1_me}), .i_den (r1_w.twod), .o_quo (q_e)
    );
    spc_div u_div_kd (
        .i_clk (i_clk), .i_en (en),
        .i_num ({32'd0, r1_w.k, 16'd0}), .i_den (r1_w.twod), .o_quo (q_kd)
    );
    spc_div u_div_kl (
        .i_clk (i_clk), .i_en (en),
        .i_num ({32'd0, r1_w.k, 16'd0}), .i_den (r1_w.len), .o_quo (q_kl)
    );
    for (genvar i = 0; i < 3; i++) begin : g_t1
        spc_div u_div (
            .i_clk (i_clk), .i_en (en),
            .i_num ({r1_mt[i], 16'd0}), .i_den (r1_w.len), .o_quo (q_t1[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d1_w[0] <= r1_w;
            for (int i = 1; i < DIV_STEPS; i++) begin
                r_d1_w[i] <= r_d1_w[i-1];
            end
        end
    end

    assign w1 = r_d1_w[DIV_STEPS-1];

    // The 48-bit by 32-bit products are split into two partial products.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_ks.w  <= w1;
            r2_ks.kl <= q_kl;
            r2_ks.kd <= q_kd;
            for (int i = 0; i < 3; i++) begin
                r2_mf[i] <= 64'(q_e[31:0]) * 64'(w1.mag[i]);
            end
            for (int p = 0; p < NPAIR; p++) begin
                r2_hi[p] <= 48'(q_t1[PAIR_I[p]][47:32]) * 48'(w1.mag[PAIR_J[p]]);
                r2_lo[p] <= 64'(q_t1[PAIR_I[p]][31:0]) * 64'(w1.mag[PAIR_J[p]]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_ks <= r2_ks;
            r3_mf <= r2_mf;
            for (int p = 0; p < NPAIR; p++) begin
                r3_t2n[p] <= {r2_hi[p], 32'd0} + DIV_NW'(r2_lo[p]);
            end
        end
    end

    // Second bank: force components and the second stiffness quotient.
    for (genvar i = 0; i < 3; i++) begin : g_force
        spc_div u_div (
            .i_clk (i_clk), .i_en (en),
            .i_num ({16'd0, r3_mf[i]}), .i_den (r3_ks.w.len), .o_quo (q_f[i])
        );
    end
    for (genvar p = 0; p < NPAIR; p++) begin : g_t2
        spc_div u_div (
            .i_clk (i_clk), .i_en (en),
            .i_num (r3_t2n[p]), .i_den (r3_ks.w.len), .o_quo (q_t2[p])
        );
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d2[0] <= r3_ks;
            for (int i = 1; i < DIV_STEPS; i++) begin
                r_d2[i] <= r_d2[i-1];
            end
        end
    end

    assign ks2 = r_d2[DIV_STEPS-1];

    // Third bank: last division by L of the stiffness terms.
    for (genvar p = 0; p < NPAIR; p++) begin : g_m
        spc_div u_div (
            .i_clk (i_clk), .i_en (en),
            .i_num ({32'd0, q_t2[p]}), .i_den (ks2.w.len), .o_quo (q_m[p])
        );
    end

    always_comb begin
        n_fs.ks = ks2;
        n_fs.f  = q_f;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d3[0] <= n_fs;
            for (int i = 1; i < DIV_STEPS; i++) begin
                r_d3[i] <= r_d3[i-1];
            end
        end
    end

    assign fs3     = r_d3[DIV_STEPS-1];
    assign n_kdiff = $signed({2'b00, fs3.ks.kd}) - $signed({2'b00, fs3.ks.kl});

    always_comb begin
        n_out            = '0;
        n_out.seg_length = fs3.ks.w.seg_length;
        n_out.in_contact = fs3.ks.w.in_contact;
        n_out.degenerate = fs3.ks.w.degenerate;
        if (fs3.ks.w.active) begin
            n_out.force_x  = sat48(signed_mag(fs3.f[0], fs3.ks.w.neg[0]));
            n_out.force_y  = sat48(signed_mag(fs3.f[1], fs3.ks.w.neg[1]));
            n_out.force_z  = sat48(signed_mag(fs3.f[2], fs3.ks.w.neg[2]));
            n_out.stiff_xx = sat48(n_kdiff + signed_mag(q_m[0], 1'b0));
            n_out.stiff_yy = sat48(n_kdiff + signed_mag(q_m[1], 1'b0));
            n_out.stiff_zz = sat48(n_kdiff + signed_mag(q_m[2], 1'b0));
            n_out.stiff_xy = sat48(signed_mag(q_m[3], fs3.ks.w.neg[0] ^ fs3.ks.w.neg[1]));
            n_out.stiff_xz = sat48(signed_mag(q_m[4], fs3.ks.w.neg[0] ^ fs3.ks.w.neg[2]));
            n_out.stiff_yz = sat48(signed_mag(q_m[5], fs3.ks.w.neg[1] ^ fs3.ks.w.neg[2]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v        <= 1'b0;
            r_d1_v      <= '0;
            r2_v        <= 1'b0;
            r3_v        <= 1'b0;
            r_d2_v      <= '0;
            r_d3_v      <= '0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r1_v        <= pop;
            r_d1_v      <= {r_d1_v[DIV_STEPS-2:0], r1_v};
            r2_v        <= r_d1_v[DIV_STEPS-1];
            r3_v        <= r2_v;
            r_d2_v      <= {r_d2_v[DIV_STEPS-2:0], r3_v};
            r_d3_v      <= {r_d3_v[DIV_STEPS-2:0], r_d2_v[DIV_STEPS-1]};
            r_out_valid <= r_d3_v[DIV_STEPS-1];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `SPC_ASSERT_IMP(a_deg_in_contact, r_out_valid && r_out.degenerate, r_out.in_contact, "degenerate without contact")
    `SPC_ASSERT_IMP(a_deg_zero_len, r_out_valid && r_out.degenerate, r_out.seg_length == '0, "degenerate with length")
    `SPC_ASSERT_IMP(a_free_zero, r_out_valid && !r_out.in_contact, r_out.force_x == '0 && r_out.stiff_xx == '0, "load without contact")

endmodule

// ===== rtl/segment_penalty_contact.sv =====
// Top level of the rope segment penalty contact kernel.
// Depends on spc_pkg, spc_front, spc_queue, spc_back and spc_div.

// Accepts one segment per clock while o_in_stall is low and returns one result per segment,
// in order. Each segment passes the 37 register stages of the front end (differences,
// squares, a 34-stage square root), the four-entry queue and the back end, which is built
// from three chained banks of 48-stage pipelined dividers. A stalled output freezes only
// the back end; the front end keeps taking segments until the queue fills.
module segment_penalty_contact (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  spc_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output spc_pkg::t_out o_out_data
);
    import spc_pkg::*;

    logic  push;
    logic  pop;
    logic  q_full;
    logic  q_valid;
    t_work front_work;
    t_work q_work;

    spc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_push     (push),
        .o_work     (front_work),
        .i_q_full   (q_full)
    );

    spc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_work),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_work)
    );

    spc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_data    (q_work),
        .o_q_pop     (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== tb/segment_penalty_contact_checker.sv =====
// Checker for segment_penalty_contact: watches both channels, predicts each result
// from the accepted segment and compares it field by field. Depends on spc_pkg.
module segment_penalty_contact_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_stall,
    input  spc_pkg::t_in  i_in_data,
    input  logic          i_out_valid,
    input  logic          i_out_stall,
    input  spc_pkg::t_out i_out_data,
    output int            o_errors,
    output int            o_pending
);
    import spc_pkg::*;

    localparam logic [63:0] ALL_ONES = '1;
    localparam logic signed [65:0] LIM_HI = 66'sd140737488355327;
    localparam logic signed [65:0] LIM_LO = -66'sd140737488355328;

    t_out contact_results[$];

    // floor(a*b/d) clipped to 64 bits.
    function automatic logic [63:0] scaled_quotient(input logic [63:0] a, input logic [63:0] b,
                                                    input logic [63:0] d);
        logic [127:0] q;
        if (d == 0) return ALL_ONES;
        q = (128'(a) * 128'(b)) / 128'(d);
        return (q[127:64] != 0) ? ALL_ONES : q[63:0];
    endfunction

    function automatic logic signed [65:0] signed_clip(input logic [63:0] m, input logic neg);
        logic signed [65:0] c;
        c = (m > 64'h7FFF_FFFF_FFFF) ? 66'sd140737488355328 : $signed({2'b00, m});
        return neg ? -c : c;
    endfunction

    function automatic logic [47:0] clamp48(input logic signed [65:0] v);
        if (v > LIM_HI) return LIM_HI[47:0];
        if (v < LIM_LO) return LIM_LO[47:0];
        return v[47:0];
    endfunction

    function automatic logic [63:0] stiffness_mag(input logic [63:0] k, input logic [63:0] ai,
                                                  input logic [63:0] aj, input logic [63:0] len);
        logic [63:0] t;
        t = scaled_quotient(k << 16, ai, len);
        t = scaled_quotient(t, aj, len);
        return t / len;
    endfunction

    function automatic t_out predict_contact(input t_in s);
        t_out r;
        logic signed [32:0] d[3];
        logic [63:0] a[3];
        logic [2:0] neg;
        logic [127:0] sum, trial;
        logic [63:0] len, twod, k, e, kl, kd;
        logic signed [65:0] base;
        d[0] = 33'(s.node_b_x) - 33'(s.node_a_x);
        d[1] = 33'(s.node_b_y) - 33'(s.node_a_y);
        d[2] = 33'(s.node_b_z) - 33'(s.node_a_z);
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            neg[i] = d[i][32];
            a[i] = neg[i] ? 64'(-66'(d[i])) : 64'(d[i]);
            sum += 128'(a[i]) * 128'(a[i]);
        end
        len = 0;
        for (int b = 33; b >= 0; b--) begin
            trial = 128'(len | (64'd1 << b));
            if (trial * trial <= sum) len = trial[63:0];
        end
        twod = 64'(s.rope_diameter) * 2;
        k = 64'(s.tensile_stiffness);
        r = '0;
        r.seg_length = (len > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : len[31:0];
        r.in_contact = len < twod;
        r.degenerate = r.in_contact && len == 0;
        if (r.in_contact && len != 0) begin
            e = scaled_quotient(k, twod - len, twod);
            kl = (k << 16) / len;
            kd = (k << 16) / twod;
            base = $signed({2'b00, kd}) - $signed({2'b00, kl});
            r.force_x = clamp48(signed_clip(scaled_quotient(e, a[0], len), neg[0]));
            r.force_y = clamp48(signed_clip(scaled_quotient(e, a[1], len), neg[1]));
            r.force_z = clamp48(signed_clip(scaled_quotient(e, a[2], len), neg[2]));
            r.stiff_xx = clamp48(base + signed_clip(stiffness_mag(k, a[0], a[0], len), 1'b0));
            r.stiff_yy = clamp48(base + signed_clip(stiffness_mag(k, a[1], a[1], len), 1'b0));
            r.stiff_zz = clamp48(base + signed_clip(stiffness_mag(k, a[2], a[2], len), 1'b0));
            r.stiff_xy = clamp48(signed_clip(stiffness_mag(k, a[0], a[1], len), neg[0] ^ neg[1]));
            r.stiff_xz = clamp48(signed_clip(stiffness_mag(k, a[0], a[2], len), neg[0] ^ neg[2]));
            r.stiff_yz = clamp48(signed_clip(stiffness_mag(k, a[1], a[2], len), neg[1] ^ neg[2]));
        end
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [47:0] exp_v,
                                 input logic [47:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
            o_errors++;
        end
    endtask

    initial o_errors = 0;
    assign o_pending = contact_results.size();

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && i_in_valid && !i_in_stall) begin
            contact_results.push_back(predict_contact(i_in_data));
        end
        if (i_rst_n && i_out_valid && !i_out_stall) begin
            if (contact_results.size() == 0) begin
                $display("%0t: unexpected result transfer %h", $time, i_out_data);
                o_errors++;
            end else begin
                want = contact_results.pop_front();
                compare_field("seg_length", 48'(want.seg_length), 48'(i_out_data.seg_length));
                compare_field("in_contact", 48'(want.in_contact), 48'(i_out_data.in_contact));
                compare_field("degenerate", 48'(want.degenerate), 48'(i_out_data.degenerate));
                compare_field("force_x", want.force_x, i_out_data.force_x);
                compare_field("force_y", want.force_y, i_out_data.force_y);
                compare_field("force_z", want.force_z, i_out_data.force_z);
                compare_field("stiff_xx", want.stiff_xx, i_out_data.stiff_xx);
                compare_field("stiff_yy", want.stiff_yy, i_out_data.stiff_yy);
                compare_field("stiff_zz", want.stiff_zz, i_out_data.stiff_zz);
                compare_field("stiff_xy", want.stiff_xy, i_out_data.stiff_xy);
                compare_field("stiff_xz", want.stiff_xz, i_out_data.stiff_xz);
                compare_field("stiff_yz", want.stiff_yz, i_out_data.stiff_yz);
            end
        end
    end

endmodule

// ===== tb/testbench.sv =====
// Top of the segment_penalty_contact testbench: clock, reset, segment stimulus,
// random stalls and the verdict. Depends on spc_pkg, segment_penalty_contact and segment_penalty_contact_checker.
module testbench;
    import spc_pkg::*;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_in_valid = 0;
    logic i_out_stall = 0;
    t_in  i_in_data = '0;
    logic o_in_stall;
    logic o_out_valid;
    t_out o_out_data;
    int   errors;
    int   pending;
    int   cycles = 0;
    bit   calm = 0;

    segment_penalty_contact DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data)
    );

    segment_penalty_contact_checker checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_stall(o_in_stall), .i_in_data(i_in_data),
        .i_out_valid(o_out_valid), .i_out_stall(i_out_stall), .i_out_data(o_out_data),
        .o_errors(errors), .o_pending(pending)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("segment_penalty_contact test failed");
            $finish;
        end
    end

    // Random number with a random count of leading zeros, so small values are common.
    function automatic logic [31:0] any_width();
        return $urandom >> $urandom_range(0, 31);
    endfunction

    task automatic send_segment(input t_in s);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= s;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic send_nodes(input logic [31:0] ax, ay, az, bx, by, bz, dia, k);
        t_in s;
        s = '{ax, ay, az, bx, by, bz, dia, k};
        send_segment(s);
    endtask

    // A segment whose length is mostly below twice the diameter.
    function automatic t_in near_contact();
        t_in s;
        logic [63:0] span;
        logic [32:0] off;
        s.rope_diameter = any_width();
        s.tensile_stiffness = ($urandom_range(0, 7) == 0) ? $urandom : any_width();
        s.node_a_x = $urandom;
        s.node_a_y = $urandom;
        s.node_a_z = $urandom;
        span = 64'(s.rope_diameter) + 1;
        off = 33'(64'($urandom) % span);
        s.node_b_x = s.node_a_x + ($urandom_range(0, 1) ? -off[31:0] : off[31:0]);
        off = 33'(64'($urandom) % span);
        s.node_b_y = s.node_a_y + ($urandom_range(0, 1) ? -off[31:0] : off[31:0]);
        off = 33'(64'($urandom) % span);
        s.node_b_z = s.node_a_z + ($urandom_range(0, 1) ? -off[31:0] : off[31:0]);
        if ($urandom_range(0, 15) == 0) s.node_b_x = s.node_a_x;
        return s;
    endfunction

    // Each result is held off for a random number of cycles, with calm stretches.
    initial begin
        int hold;
        @(posedge i_rst_n);
        forever begin
            hold = calm ? 0 : $urandom_range(0, 7);
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    initial begin
        t_in s;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Coincident nodes, zero diameter, coordinate and size extremes.
        send_nodes(0, 0, 0, 0, 0, 0, 0, 0);
        send_nodes(5, 6, 7, 5, 6, 7, 32'h0001_0000, 32'h0001_0000);
        send_nodes(0, 0, 0, 32'h0001_0000, 0, 0, 0, 32'hFFFF_FFFF);
        send_nodes(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_nodes(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                   32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_nodes(0, 0, 0, 1, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_nodes(0, 0, 0, 0, 32'hFFFF_FFFF, 0, 1, 32'hFFFF_FFFF);
        send_nodes(0, 0, 0, 0, 0, 1, 1, 32'hFFFF_FFFF);
        send_nodes(0, 0, 0, 1, 1, 1, 1, 32'hFFFF_FFFF);
        send_nodes(0, 0, 0, 32'h0000_8000, 32'hFFFF_8000, 32'h0000_8000,
                   32'h0001_0000, 32'h000A_0000);
        send_nodes(10, 20, 30, 10, 20, 30, 0, 32'h0001_0000);
        send_nodes(0, 0, 0, 32'h0002_0000, 0, 0, 32'h0001_0000, 32'h0001_0000);
        send_nodes(0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        send_nodes(32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                   32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

        for (int n = 0; n < 1600; n++) begin
            if (n % 200 == 0) calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 4) == 0) begin
                s = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom};
            end else begin
                s = near_contact();
            end
            send_segment(s);
        end
        i_in_valid <= 1'b0;
        calm = 0;

        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (errors == 0) begin
            $display("segment_penalty_contact test passed");
        end else begin
            $display("segment_penalty_contact test failed");
        end
        $finish;
    end

endmodule
